### design/motor_feedback_packet_parser_core_assert.svh
// Assertion macros shared by the motor feedback parser RTL.
// No dependencies; files include this header by its bare name.
`ifndef MOTOR_FEEDBACK_PACKET_PARSER_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_PACKET_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MFPP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfpp assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define MFPP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfpp assertion failed: next-cycle implication");

`endif

### design/mfpp_pkg.sv
// Constants shared by the motor feedback packet parser.
// No dependencies.
`default_nettype none

package mfpp_pkg;

   // Sync and id byte limits
   localparam logic [7:0] SYNC_A = 8'd183;
   localparam logic [7:0] SYNC_B = 8'd184;
   localparam logic [7:0] ID_MIN = 8'd1;
   localparam logic [7:0] ID_MAX = 8'd254;

   // Configuration register indexes
   localparam logic [7:0] CSR_DRIVER_ID      = 8'd0;
   localparam logic [7:0] CSR_MAIN_DATA_KIND = 8'd1;

   // Configuration reset values
   localparam logic [7:0] DRIVER_ID_RST      = 8'd1;
   localparam logic [7:0] MAIN_DATA_KIND_RST = 8'd193;

   // Frame byte positions that are captured
   localparam logic [7:0] POS_ID     = 8'd2;
   localparam logic [7:0] POS_KIND   = 8'd3;
   localparam logic [7:0] POS_TICKS0 = 8'd15;
   localparam logic [7:0] POS_TICKS1 = 8'd16;
   localparam logic [7:0] POS_TICKS2 = 8'd17;
   localparam logic [7:0] POS_TICKS3 = 8'd18;

   // Capture slots
   localparam int CAP_DEPTH = 6;
   localparam logic [2:0] CAP_ID     = 3'd0;
   localparam logic [2:0] CAP_KIND   = 3'd1;
   localparam logic [2:0] CAP_TICKS0 = 3'd2;
   localparam logic [2:0] CAP_TICKS1 = 3'd3;
   localparam logic [2:0] CAP_TICKS2 = 3'd4;
   localparam logic [2:0] CAP_TICKS3 = 3'd5;

   typedef logic [7:0] byte_type;

endpackage

`default_nettype wire

### design/motor_feedback_packet_parser_core.sv
// Motor feedback packet parser: sync/length/checksum deframer, one module.
// Depends on mfpp_pkg and motor_feedback_packet_parser_core_assert.svh.
//
// One received byte goes in per beat and exactly one result beat comes out for it,
// registered in the cycle after the byte is accepted. The frame-state update for a byte
// is combinational logic from the parser state registers to the result register, so
// the block takes a byte every cycle as long as the result side keeps taking beats; a
// result waiting in the output register still lets the next byte in if rsp_ready is
// high in that same cycle. frame_good flags a byte that closed a frame whose 8-bit sum
// is zero; feedback_update flags a good frame that also carries the configured id and
// main-data kind, at which point bytes 15..18 of the frame are latched little-endian
// into position_ticks. Configuration writes are always taken (csr_ready is tied high)
// and should be made while the parser is idle.
`default_nettype none

`include "motor_feedback_packet_parser_core_assert.svh"

module motor_feedback_packet_parser_core #(
   parameter int FRAME_BYTES_MAX = 26,
   parameter int DATA_BYTES_MAX  = 23
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // byte input channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_rx_byte,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_frame_good,
   output logic                    rsp_feedback_update,
   output logic signed [31:0]      rsp_position_ticks,
   output logic                    rsp_feedback_valid,
   // configuration write channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [7:0]         csr_index,
   input  wire logic [7:0]         csr_wdata
);

   localparam logic [7:0] FrameMax = 8'(FRAME_BYTES_MAX);
   localparam logic [7:0] DataMax  = 8'(DATA_BYTES_MAX);

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_ID    = 3'd1,
      PH_KIND  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   // Parser state
   phase_type          phase_ff, phase_in;
   logic [7:0]         byte_index_ff, byte_index_in;
   logic [7:0]         declared_length_ff, declared_length_in;
   logic [7:0]         data_index_ff, data_index_in;
   logic [7:0]         running_sum_ff, running_sum_in;
   logic [1:0]         sync_seen_ff, sync_seen_in;
   mfpp_pkg::byte_type capture_ff [mfpp_pkg::CAP_DEPTH];
   mfpp_pkg::byte_type capture_in [mfpp_pkg::CAP_DEPTH];
   logic [31:0]        position_ff, position_in;
   logic               feedback_seen_ff, feedback_seen_in;

   // Configuration
   logic [7:0]         driver_id_ff;
   logic [7:0]         main_data_kind_ff;

   // Result register
   logic               rsp_valid_ff;
   logic               frame_good_ff, frame_good_in;
   logic               update_ff, update_in;

   logic               req_fire;
   logic               take_byte;
   logic               do_restart;
   logic [7:0]         data_next;
   logic [7:0]         sum_next;

   // Handshake: output register is free or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign sum_next  = running_sum_ff + req_rx_byte;
   assign data_next = data_index_ff + 8'd1;

   // Per-byte frame state update
   always_comb begin
      phase_in           = phase_ff;
      byte_index_in      = byte_index_ff;
      declared_length_in = declared_length_ff;
      data_index_in      = data_index_ff;
      running_sum_in     = running_sum_ff;
      sync_seen_in       = sync_seen_ff;
      capture_in         = capture_ff;
      frame_good_in      = 1'b0;
      take_byte          = 1'b0;
      do_restart         = 1'b0;

      if (byte_index_ff >= FrameMax) begin
         // frame overflow: byte dropped
         do_restart = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == mfpp_pkg::SYNC_A || req_rx_byte == mfpp_pkg::SYNC_B) begin
                  take_byte = 1'b1;
                  if (sync_seen_ff == 2'd1) begin
                     sync_seen_in = 2'd0;
                     phase_in     = PH_ID;
                  end else begin
                     sync_seen_in = sync_seen_ff + 2'd1;
                  end
               end else begin
                  do_restart = 1'b1;
               end
            end
            PH_ID: begin
               if (req_rx_byte >= mfpp_pkg::ID_MIN && req_rx_byte <= mfpp_pkg::ID_MAX) begin
                  take_byte = 1'b1;
                  phase_in  = PH_KIND;
               end else begin
                  do_restart = 1'b1;
               end
            end
            PH_KIND: begin
               take_byte = 1'b1;
               phase_in  = PH_LEN;
            end
            PH_LEN: begin
               take_byte          = 1'b1;
               declared_length_in = req_rx_byte;
               data_index_in      = 8'd0;
               phase_in           = PH_DATA;
            end
            PH_DATA: begin
               take_byte     = 1'b1;
               data_index_in = data_next;
               if (data_next >= DataMax) begin
                  do_restart = 1'b1;
               end else if (data_next >= declared_length_ff) begin
                  phase_in = PH_CHECK;
               end
            end
            PH_CHECK: begin
               take_byte     = 1'b1;
               frame_good_in = (sum_next == 8'd0);
               do_restart    = 1'b1;
            end
            default: begin
               do_restart = 1'b1;
            end
         endcase
      end

      // store the byte at its frame position
      if (take_byte) begin
         running_sum_in = sum_next;
         byte_index_in  = byte_index_ff + 8'd1;
         case (byte_index_ff)
            mfpp_pkg::POS_ID:     capture_in[mfpp_pkg::CAP_ID]     = req_rx_byte;
            mfpp_pkg::POS_KIND:   capture_in[mfpp_pkg::CAP_KIND]   = req_rx_byte;
            mfpp_pkg::POS_TICKS0: capture_in[mfpp_pkg::CAP_TICKS0] = req_rx_byte;
            mfpp_pkg::POS_TICKS1: capture_in[mfpp_pkg::CAP_TICKS1] = req_rx_byte;
            mfpp_pkg::POS_TICKS2: capture_in[mfpp_pkg::CAP_TICKS2] = req_rx_byte;
            mfpp_pkg::POS_TICKS3: capture_in[mfpp_pkg::CAP_TICKS3] = req_rx_byte;
            default: ;
         endcase
      end

      // restart keeps captures, position and feedback flag
      if (do_restart) begin
         phase_in           = PH_HUNT;
         byte_index_in      = 8'd0;
         declared_length_in = 8'd0;
         data_index_in      = 8'd0;
         running_sum_in     = 8'd0;
         sync_seen_in       = 2'd0;
      end
   end

   // Feedback latch on a good matching main-data frame
   always_comb begin
      update_in = frame_good_in
               && capture_in[mfpp_pkg::CAP_KIND] == main_data_kind_ff
               && capture_in[mfpp_pkg::CAP_ID] == driver_id_ff;
      position_in      = position_ff;
      feedback_seen_in = feedback_seen_ff;
      if (update_in) begin
         position_in = {capture_in[mfpp_pkg::CAP_TICKS3], capture_in[mfpp_pkg::CAP_TICKS2],
                        capture_in[mfpp_pkg::CAP_TICKS1], capture_in[mfpp_pkg::CAP_TICKS0]};
         feedback_seen_in = 1'b1;
      end
   end

   // State, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT;
         byte_index_ff      <= 8'd0;
         declared_length_ff <= 8'd0;
         data_index_ff      <= 8'd0;
         running_sum_ff     <= 8'd0;
         sync_seen_ff       <= 2'd0;
         for (int i = 0; i < mfpp_pkg::CAP_DEPTH; i++) begin
            capture_ff[i] <= 8'd0;
         end
         position_ff        <= 32'd0;
         feedback_seen_ff   <= 1'b0;
         driver_id_ff       <= mfpp_pkg::DRIVER_ID_RST;
         main_data_kind_ff  <= mfpp_pkg::MAIN_DATA_KIND_RST;
         rsp_valid_ff       <= 1'b0;
         frame_good_ff      <= 1'b0;
         update_ff          <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               mfpp_pkg::CSR_DRIVER_ID:      driver_id_ff      <= csr_wdata;
               mfpp_pkg::CSR_MAIN_DATA_KIND: main_data_kind_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_fire) begin
            phase_ff           <= phase_in;
            byte_index_ff      <= byte_index_in;
            declared_length_ff <= declared_length_in;
            data_index_ff      <= data_index_in;
            running_sum_ff     <= running_sum_in;
            sync_seen_ff       <= sync_seen_in;
            capture_ff         <= capture_in;
            position_ff        <= position_in;
            feedback_seen_ff   <= feedback_seen_in;
            frame_good_ff      <= frame_good_in;
            update_ff          <= update_in;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_good      = frame_good_ff;
   assign rsp_feedback_update = update_ff;
   assign rsp_position_ticks  = signed'(position_ff);
   assign rsp_feedback_valid  = feedback_seen_ff;

   // Checks
   `MFPP_ASSERT_IMP(a_update_needs_good, clock, reset,
      rsp_valid_ff && update_ff, frame_good_ff && feedback_seen_ff)
   `MFPP_ASSERT_IMP(a_index_bounded, clock, reset,
      1'b1, byte_index_ff <= FrameMax)
   `MFPP_ASSERT_IMP(a_hunt_clean, clock, reset,
      phase_ff == PH_HUNT, declared_length_ff == 8'd0 && data_index_ff == 8'd0)
   `MFPP_ASSERT_IMP(a_sync_only_hunting, clock, reset,
      phase_ff != PH_HUNT, sync_seen_ff == 2'd0)
   `MFPP_ASSERT_NXT(a_update_sets_seen, clock, reset,
      req_fire && update_in, feedback_seen_ff && rsp_valid_ff)

endmodule

`default_nettype wire

### verif/tb_motor_feedback_packet_parser_core.sv
// Testbench for motor_feedback_packet_parser_core: directed byte table, then random frames.
// Every result beat is checked against the directed table or a local frame-parser predictor.
// Depends on mfpp_pkg and the parser core RTL.
`default_nettype none

module tb_motor_feedback_packet_parser_core;

   localparam int FRAME_BYTES_MAX = 26;
   localparam int DATA_BYTES_MAX  = 23;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int MAX_DATA_SENT   = 30;

   typedef enum logic [2:0] {
      PH_HUNT, PH_ID, PH_KIND, PH_LEN, PH_DATA, PH_SUM
   } parse_phase_type;

   typedef struct packed {
      logic               frame_good;
      logic               feedback_update;
      logic signed [31:0] position_ticks;
      logic               feedback_valid;
   } fb_result_type;

   typedef struct {
      mfpp_pkg::byte_type rx;
      bit                 typed;
      fb_result_type      want;
   } byte_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_frame_good;
   logic        rsp_feedback_update;
   logic signed [31:0] rsp_position_ticks;
   logic        rsp_feedback_valid;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   motor_feedback_packet_parser_core #(
      .FRAME_BYTES_MAX(FRAME_BYTES_MAX),
      .DATA_BYTES_MAX (DATA_BYTES_MAX)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_good     (rsp_frame_good),
      .rsp_feedback_update(rsp_feedback_update),
      .rsp_position_ticks (rsp_position_ticks),
      .rsp_feedback_valid (rsp_feedback_valid),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Clock
   initial begin
      forever #4 clock = ~clock;
   end

   // Parser model state and configuration
   mfpp_pkg::byte_type cfg_driver_id = mfpp_pkg::DRIVER_ID_RST;
   mfpp_pkg::byte_type cfg_main_kind = mfpp_pkg::MAIN_DATA_KIND_RST;
   parse_phase_type    p_phase = PH_HUNT;
   mfpp_pkg::byte_type p_index = '0;
   mfpp_pkg::byte_type p_len = '0;
   mfpp_pkg::byte_type p_data = '0;
   mfpp_pkg::byte_type p_sum = '0;
   logic [1:0]         p_sync = '0;
   mfpp_pkg::byte_type cap_bytes [mfpp_pkg::CAP_DEPTH] = '{default: '0};
   logic [31:0]        pos_held = '0;
   logic               fb_seen = 1'b0;

   fb_result_type pending_results [$];
   byte_row_type  dir_rows [$];
   int            errors = 0;
   int            cycles = 0;
   bit            quiet = 1'b0;
   int            hold_asks = 0;
   int            hold_taken = 0;
   int            rsp_stall_left = 0;

   task automatic restart_frame();
      p_phase = PH_HUNT;
      p_index = '0;
      p_len   = '0;
      p_data  = '0;
      p_sum   = '0;
      p_sync  = '0;
   endtask

   // Store a frame byte: capture slots, running sum, byte index
   task automatic store_byte(input mfpp_pkg::byte_type b);
      if (p_index == mfpp_pkg::POS_ID) cap_bytes[mfpp_pkg::CAP_ID] = b;
      else if (p_index == mfpp_pkg::POS_KIND) cap_bytes[mfpp_pkg::CAP_KIND] = b;
      else if (p_index >= mfpp_pkg::POS_TICKS0 && p_index <= mfpp_pkg::POS_TICKS3)
         cap_bytes[mfpp_pkg::CAP_TICKS0 + 3'(p_index - mfpp_pkg::POS_TICKS0)] = b;
      p_sum   = p_sum + b;
      p_index = p_index + 8'd1;
   endtask

   // Advance the parser by one byte and form the result beat it causes
   task automatic parse_rx_byte(input mfpp_pkg::byte_type b, output fb_result_type r);
      logic good;
      good = 1'b0;
      if (p_index >= FRAME_BYTES_MAX) begin
         restart_frame();
      end else begin
         case (p_phase)
            PH_HUNT: begin
               if (b == mfpp_pkg::SYNC_A || b == mfpp_pkg::SYNC_B) begin
                  store_byte(b);
                  p_sync = p_sync + 2'd1;
                  if (p_sync == 2'd2) begin
                     p_sync  = '0;
                     p_phase = PH_ID;
                  end
               end else begin
                  restart_frame();
               end
            end
            PH_ID: begin
               if (b >= mfpp_pkg::ID_MIN && b <= mfpp_pkg::ID_MAX) begin
                  store_byte(b);
                  p_phase = PH_KIND;
               end else begin
                  restart_frame();
               end
            end
            PH_KIND: begin
               store_byte(b);
               p_phase = PH_LEN;
            end
            PH_LEN: begin
               p_len  = b;
               p_data = '0;
               store_byte(b);
               p_phase = PH_DATA;
            end
            PH_DATA: begin
               store_byte(b);
               p_data = p_data + 8'd1;
               if (p_data >= DATA_BYTES_MAX) restart_frame();
               else if (p_data >= p_len) p_phase = PH_SUM;
            end
            PH_SUM: begin
               store_byte(b);
               good = (p_sum == 8'd0);
               restart_frame();
            end
            default: restart_frame();
         endcase
      end
      r.feedback_update = 1'b0;
      if (good && cap_bytes[mfpp_pkg::CAP_KIND] == cfg_main_kind
               && cap_bytes[mfpp_pkg::CAP_ID] == cfg_driver_id)
      begin
         pos_held = {cap_bytes[mfpp_pkg::CAP_TICKS3], cap_bytes[mfpp_pkg::CAP_TICKS2],
                     cap_bytes[mfpp_pkg::CAP_TICKS1], cap_bytes[mfpp_pkg::CAP_TICKS0]};
         fb_seen  = 1'b1;
         r.feedback_update = 1'b1;
      end
      r.frame_good     = good;
      r.position_ticks = pos_held;
      r.feedback_valid = fb_seen;
   endtask

   // Gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_row(input mfpp_pkg::byte_type rx, input int typed, input int good,
                          input int upd, input int pos, input int fv);
      byte_row_type row;
      row.rx   = rx;
      row.typed = (typed != 0);
      row.want = '{frame_good: (good != 0), feedback_update: (upd != 0), position_ticks: pos,
                   feedback_valid: (fv != 0)};
      dir_rows.push_back(row);
   endtask

   // Offer one byte beat; called at a rising edge, returns at the accepting edge
   task automatic send_rx_byte(input mfpp_pkg::byte_type b, input bit typed,
                               input fb_result_type want);
      int gap;
      bit acc;
      fb_result_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         acc = req_valid && req_ready;
         @(posedge clock);
      end while (!acc);
      parse_rx_byte(b, r);
      pending_results.push_back(typed ? want : r);
   endtask

   // Register write beat; drops csr_valid and leaves the channel idle before returning
   task automatic write_csr(input logic [7:0] idx, input mfpp_pkg::byte_type val);
      bit acc;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do begin
         @(negedge clock);
         acc = csr_valid && csr_ready;
         @(posedge clock);
      end while (!acc);
      if (idx == mfpp_pkg::CSR_DRIVER_ID) cfg_driver_id = val;
      else if (idx == mfpp_pkg::CSR_MAIN_DATA_KIND) cfg_main_kind = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every result beat has come back, then let the core settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      if (errors <= 50)
         $display("mismatch: %s got %0h want %0h at cycle %0d", field, got, want, cycles);
   endtask

   // Result receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_taken != hold_asks) begin
         hold_taken <= hold_taken + 1;
         rsp_stall_left <= RSP_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_stall_left <= pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      fb_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with no byte pending", rsp_position_ticks, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_frame_good !== want.frame_good)
               report_mismatch("frame_good", 32'(rsp_frame_good), 32'(want.frame_good));
            if (rsp_feedback_update !== want.feedback_update)
               report_mismatch("feedback_update", 32'(rsp_feedback_update),
                               32'(want.feedback_update));
            if (rsp_position_ticks !== want.position_ticks)
               report_mismatch("position_ticks", rsp_position_ticks, want.position_ticks);
            if (rsp_feedback_valid !== want.feedback_valid)
               report_mismatch("feedback_valid", 32'(rsp_feedback_valid),
                               32'(want.feedback_valid));
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Stimulus
   initial begin
      mfpp_pkg::byte_type frame_q [$];
      mfpp_pkg::byte_type sum;
      mfpp_pkg::byte_type id_b;
      mfpp_pkg::byte_type new_id;
      mfpp_pkg::byte_type new_kind;
      int                 len;
      int                 ndata;
      int                 pick;
      int                 phase_items;
      fb_result_type      none;

      none = '0;

      // Directed bytes at reset configuration (id 1, main kind 193)
      add_row(8'h00, 1, 0, 0, 0, 0);         // bad sync byte
      // shortest good matching frame: zero length, stale zero position latched
      add_row(mfpp_pkg::SYNC_A, 1, 0, 0, 0, 0);
      add_row(mfpp_pkg::SYNC_B, 1, 0, 0, 0, 0);
      add_row(mfpp_pkg::ID_MIN, 1, 0, 0, 0, 0);
      add_row(mfpp_pkg::MAIN_DATA_KIND_RST, 1, 0, 0, 0, 0);
      add_row(8'd0, 1, 0, 0, 0, 0);
      add_row(8'd0, 1, 0, 0, 0, 0);
      add_row(8'd207, 1, 1, 1, 0, 1);
      // id byte 0 and id byte 255 restart the search
      add_row(mfpp_pkg::SYNC_A, 1, 0, 0, 0, 1);
      add_row(mfpp_pkg::SYNC_A, 1, 0, 0, 0, 1);
      add_row(mfpp_pkg::ID_MIN - 8'd1, 1, 0, 0, 0, 1);
      add_row(mfpp_pkg::SYNC_B, 1, 0, 0, 0, 1);
      add_row(mfpp_pkg::SYNC_B, 1, 0, 0, 0, 1);
      add_row(mfpp_pkg::ID_MAX + 8'd1, 1, 0, 0, 0, 1);
      // bad checksum
      add_row(mfpp_pkg::SYNC_A, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::SYNC_B, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::ID_MIN, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::MAIN_DATA_KIND_RST, 0, 0, 0, 0, 0);
      add_row(8'd0, 0, 0, 0, 0, 0);
      add_row(8'd0, 0, 0, 0, 0, 0);
      add_row(8'd0, 1, 0, 0, 0, 1);
      // good frame from another id: no update
      add_row(mfpp_pkg::SYNC_A, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::SYNC_B, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::ID_MAX, 0, 0, 0, 0, 0);
      add_row(mfpp_pkg::MAIN_DATA_KIND_RST, 0, 0, 0, 0, 0);
      add_row(8'd0, 0, 0, 0, 0, 0);
      add_row(8'hFF, 0, 0, 0, 0, 0);
      add_row(8'd211, 1, 1, 0, 0, 1);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_rx_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

      // Random phases, each under its own configuration
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_idle();
         case (ph)
            0: begin new_id = mfpp_pkg::ID_MAX;        new_kind = 8'h00; end
            1: begin new_id = mfpp_pkg::ID_MIN;        new_kind = 8'hFF; end
            2: begin
               new_id   = mfpp_pkg::ID_MIN - 8'd1;
               new_kind = mfpp_pkg::MAIN_DATA_KIND_RST;
            end
            3: begin
               new_id   = mfpp_pkg::ID_MAX + 8'd1;
               new_kind = mfpp_pkg::byte_type'($urandom);
            end
            4: begin
               new_id   = mfpp_pkg::byte_type'($urandom_range(mfpp_pkg::ID_MIN,
                                                              mfpp_pkg::ID_MAX));
               new_kind = mfpp_pkg::byte_type'($urandom);
            end
            default: begin
               new_id   = mfpp_pkg::DRIVER_ID_RST;
               new_kind = mfpp_pkg::MAIN_DATA_KIND_RST;
            end
         endcase
         write_csr(mfpp_pkg::CSR_DRIVER_ID, new_id);
         write_csr(mfpp_pkg::CSR_MAIN_DATA_KIND, new_kind);
         quiet = (ph == 4);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) begin
            // long receiver hold-off while bytes keep coming
            if (ph == 1 && phase_items >= 60 && hold_asks == 0) hold_asks++;
            frame_q.delete();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               // line noise
               repeat ($urandom_range(1, 4)) frame_q.push_back(mfpp_pkg::byte_type'($urandom));
            end else begin
               frame_q.push_back($urandom_range(0, 1) ? mfpp_pkg::SYNC_A : mfpp_pkg::SYNC_B);
               frame_q.push_back($urandom_range(0, 1) ? mfpp_pkg::SYNC_A : mfpp_pkg::SYNC_B);
               if (pick < 13) frame_q[$urandom_range(0, 1)] = mfpp_pkg::byte_type'($urandom);
               pick = $urandom_range(0, 99);
               if (pick < 70) id_b = cfg_driver_id;
               else if (pick < 80)
                  id_b = $urandom_range(0, 1) ? mfpp_pkg::ID_MIN - 8'd1
                                              : mfpp_pkg::ID_MAX + 8'd1;
               else id_b = mfpp_pkg::byte_type'($urandom);
               frame_q.push_back(id_b);
               frame_q.push_back($urandom_range(0, 3) != 0 ? cfg_main_kind
                                                           : mfpp_pkg::byte_type'($urandom));
               pick = $urandom_range(0, 99);
               if (pick < 45) len = $urandom_range(14, 20);
               else if (pick < 80) len = $urandom_range(0, 13);
               else if (pick < 90) len = $urandom_range(21, 30);
               else if (pick < 95) len = 255;
               else len = $urandom_range(0, 255);
               frame_q.push_back(mfpp_pkg::byte_type'(len));
               ndata = (len == 0) ? 1 : ((len > MAX_DATA_SENT) ? MAX_DATA_SENT : len);
               if ($urandom_range(0, 19) == 0) ndata = $urandom_range(0, ndata);
               repeat (ndata) frame_q.push_back(mfpp_pkg::byte_type'($urandom));
               sum = '0;
               foreach (frame_q[k]) sum = sum + frame_q[k];
               frame_q.push_back($urandom_range(0, 99) < 85
                                 ? mfpp_pkg::byte_type'(8'd0 - sum)
                                 : mfpp_pkg::byte_type'($urandom));
            end
            foreach (frame_q[k]) send_rx_byte(frame_q[k], 1'b0, none);
            phase_items += frame_q.size();
         end
      end

      // Drain
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
